FILE: rtl/core/tpsm_pkg.sv
`default_nettype none

package tpsm_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MULTI_CHIP_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ACB_STEREO        = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MONO_MASK         = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MUTE_MASK         = 8'd3;

    localparam int unsigned NUM_GEN = 3;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned GMIX_W  = 10;   // one generator, one side: up to 765
    localparam int unsigned MIX_W   = 12;

    // Select codes as held in select_code
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_GEN2 = 2'd1;
    localparam logic [1:0] SEL_GEN1 = 2'd2;
    localparam logic [1:0] SEL_GEN0 = 2'd3;

    // Target generator indexes
    localparam logic [1:0] TGT_GEN0 = 2'd0;
    localparam logic [1:0] TGT_GEN1 = 2'd1;
    localparam logic [1:0] TGT_GEN2 = 2'd2;

    // Command byte: 1 p p 1 1 1 s s
    localparam logic [2:0] CMD_FIXED_BITS = 3'b111;
    localparam logic [1:0] PAN_BOTH       = 2'b11;
    localparam int unsigned PAN_LEFT_BIT  = 1;
    localparam int unsigned PAN_RIGHT_BIT = 0;

    // Operation codes
    localparam logic OP_REG_BYTE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef struct packed {
        logic               op;
        logic [7:0]         data;
        logic [LEVEL_W-1:0] g0_level_a;
        logic [LEVEL_W-1:0] g0_level_b;
        logic [LEVEL_W-1:0] g0_level_c;
        logic [LEVEL_W-1:0] g1_level_a;
        logic [LEVEL_W-1:0] g1_level_b;
        logic [LEVEL_W-1:0] g1_level_c;
        logic [LEVEL_W-1:0] g2_level_a;
        logic [LEVEL_W-1:0] g2_level_b;
        logic [LEVEL_W-1:0] g2_level_c;
    } in_t;

    typedef struct packed {
        logic [MIX_W-1:0] mix_left;
        logic [MIX_W-1:0] mix_right;
        logic [1:0]       target_generator;
        logic             forward_select;
        logic [2:0]       tick_mask;
    } out_t;

    typedef struct packed {
        logic       multi_chip_enable;
        logic       acb_stereo;
        logic [2:0] mono_mask;
        logic [2:0] mute_mask;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         code;      // select code after this beat's decode
        logic [2:0][1:0]    pan;       // pan bits per generator
        logic               fwd;       // plain register select
    } sel_info_t;

    function automatic logic [1:0] target_of(input logic [1:0] code);
        logic [1:0] t;
        t = TGT_GEN0;
        if (code == SEL_GEN1) begin
            t = TGT_GEN1;
        end else if (code == SEL_GEN2) begin
            t = TGT_GEN2;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tpsm_cfg_regs.sv
`default_nettype none

module tpsm_cfg_regs
    import tpsm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_MULTI_CHIP_ENABLE: cfg_reg.multi_chip_enable <= cfg_data[0];
                CFG_IDX_ACB_STEREO:        cfg_reg.acb_stereo        <= cfg_data[0];
                CFG_IDX_MONO_MASK:         cfg_reg.mono_mask         <= cfg_data[2:0];
                CFG_IDX_MUTE_MASK:         cfg_reg.mute_mask         <= cfg_data[2:0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tpsm_sel_state.sv
`default_nettype none

module tpsm_sel_state
    import tpsm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       update,     // beat leaves the input register
    input  wire logic       op,
    input  wire logic [7:0] data,
    input  wire logic       multi_chip_enable,
    output sel_info_t       info
);

    logic [1:0]      code_reg, code_next;
    logic [2:0][1:0] pan_reg, pan_next;
    logic            is_cmd;

    assign is_cmd = (op == OP_REG_BYTE) && multi_chip_enable && data[7]
                    && (data[4:2] == CMD_FIXED_BITS);

    always_comb begin
        code_next = code_reg;
        pan_next  = pan_reg;
        if (is_cmd) begin
            case (data[1:0])
                SEL_GEN1: begin
                    code_next  = SEL_GEN1;
                    pan_next[1] = data[6:5];
                end
                SEL_GEN2: begin
                    code_next  = SEL_GEN2;
                    pan_next[2] = data[6:5];
                end
                default: begin   // 11 and 00 both pick generator 0
                    code_next  = SEL_GEN0;
                    pan_next[0] = data[6:5];
                end
            endcase
        end
    end

    assign info.code = code_next;
    assign info.pan  = pan_reg;   // pan only matters on ticks, which never change it
    assign info.fwd  = (op == OP_REG_BYTE) && !is_cmd && (data[7:5] == 3'b000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= SEL_GEN0;
            pan_reg  <= {NUM_GEN{PAN_BOTH}};
        end else if (update) begin
            code_reg <= code_next;
            pan_reg  <= pan_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tpsm_gen_mix.sv
`default_nettype none

module tpsm_gen_mix
    import tpsm_pkg::*;
(
    input  wire logic [LEVEL_W-1:0] level_a,
    input  wire logic [LEVEL_W-1:0] level_b,
    input  wire logic [LEVEL_W-1:0] level_c,
    input  wire logic               gen_on,     // active and not muted
    input  wire logic               mono,
    input  wire logic               acb_stereo,
    input  wire logic [1:0]         pan,
    output logic [GMIX_W-1:0]       left,
    output logic [GMIX_W-1:0]       right
);

    logic [LEVEL_W-1:0] lm;
    logic [LEVEL_W:0]   ls;
    logic [LEVEL_W:0]   rm;
    logic [GMIX_W-1:0]  rs;
    logic [GMIX_W-1:0]  lf;

    always_comb begin
        lm = (acb_stereo || mono) ? level_c : level_b;
        ls = {1'b0, lm} + {1'b0, level_a};
        rm = mono ? ls : {1'b0, level_c};
        rs = {1'b0, rm} + {2'b00, level_b};
        lf = mono ? rs : {1'b0, ls};
        left  = (gen_on && pan[PAN_LEFT_BIT])  ? lf : '0;
        right = (gen_on && pan[PAN_RIGHT_BIT]) ? rs : '0;
    end

endmodule

`default_nettype wire

FILE: rtl/core/triple_psg_select_stereo_mixer.sv
`default_nettype none

// Channel | Dir | Handshake          | Payload
// s_      | in  | s_valid / s_ready  | s_data   (in_t: op, data, nine levels)
// m_      | out | m_valid / m_ready  | m_data   (out_t: mix, target, fwd, ticks)
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (ready always high)
//
// One beat per cycle sustained while m_ready is high. A beat goes through the input
// register, then the result register, with one pass of decode and mix adders between.
// Reset (aresetn low, synchronous) clears config, selects generator 0,
// sets every pan to left+right and zeroes the stored sums.
// A stall on m_ready holds the result register; the input register still takes
// one beat if it is empty. Once both registers hold beats, s_ready follows
// m_ready in the same cycle (combinational path through the advance term).
module triple_psg_select_stereo_mixer
    import tpsm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_t                    s_data,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_t                        m_data,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    sel_info_t sel;

    // input stage
    logic in_valid_reg;
    in_t  in_reg;
    // result stage
    logic out_valid_reg;
    out_t out_reg, out_next;
    // stored sums returned on register-byte beats
    logic [MIX_W-1:0] last_left_reg, last_right_reg;

    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    tpsm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpsm_sel_state u_sel (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .update            (advance),
        .op                (in_reg.op),
        .data              (in_reg.data),
        .multi_chip_enable (cfg.multi_chip_enable),
        .info              (sel)
    );

    // Per-generator mix lanes
    logic [NUM_GEN-1:0][LEVEL_W-1:0] lvl_a, lvl_b, lvl_c;
    logic [NUM_GEN-1:0][GMIX_W-1:0]  g_left, g_right;
    logic [NUM_GEN-1:0]              g_on;
    logic [NUM_GEN-1:0][1:0]         own_code;

    assign lvl_a = {in_reg.g2_level_a, in_reg.g1_level_a, in_reg.g0_level_a};
    assign lvl_b = {in_reg.g2_level_b, in_reg.g1_level_b, in_reg.g0_level_b};
    assign lvl_c = {in_reg.g2_level_c, in_reg.g1_level_c, in_reg.g0_level_c};
    assign own_code = {SEL_GEN2, SEL_GEN1, SEL_GEN0};

    for (genvar g = 0; g < NUM_GEN; g++) begin : g_mix
        // ticks never change select_code, so sel.code is the current code here
        assign g_on[g] = (cfg.multi_chip_enable || (sel.code == own_code[g]))
                         && !cfg.mute_mask[g];

        tpsm_gen_mix u_mix (
            .level_a    (lvl_a[g]),
            .level_b    (lvl_b[g]),
            .level_c    (lvl_c[g]),
            .gen_on     (g_on[g]),
            .mono       (cfg.mono_mask[g]),
            .acb_stereo (cfg.acb_stereo),
            .pan        (sel.pan[g]),
            .left       (g_left[g]),
            .right      (g_right[g])
        );
    end

    logic [MIX_W-1:0] sum_left, sum_right;

    always_comb begin
        // max total is 2295, fits in 12 bits
        sum_left  = {2'b00, g_left[0]} + {2'b00, g_left[1]} + {2'b00, g_left[2]};
        sum_right = {2'b00, g_right[0]} + {2'b00, g_right[1]} + {2'b00, g_right[2]};

        out_next.target_generator = target_of(sel.code);
        out_next.forward_select   = sel.fwd;
        out_next.tick_mask[0]     = 1'b1;
        out_next.tick_mask[1]     = cfg.multi_chip_enable || (sel.code == SEL_GEN1);
        out_next.tick_mask[2]     = cfg.multi_chip_enable || (sel.code == SEL_GEN2);
        if (in_reg.op == OP_TICK) begin
            out_next.mix_left  = sum_left;
            out_next.mix_right = sum_right;
        end else begin
            out_next.mix_left  = last_left_reg;
            out_next.mix_right = last_right_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && (in_reg.op == OP_TICK)) begin
                last_left_reg  <= sum_left;
                last_right_reg <= sum_right;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // ---- assertions ----
    a_tick_no_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_reg.op == OP_TICK)) |=> !out_reg.forward_select)
        else $error("forward_select set on a tick beat");

    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.target_generator != 2'd3) && m_data.tick_mask[0])
        else $error("bad target or tick mask");

    a_byte_keeps_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_reg.op == OP_REG_BYTE)) |=>
            (out_reg.mix_left == $past(last_left_reg))
            && (out_reg.mix_right == $past(last_right_reg)))
        else $error("register byte changed stored sums");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.mix_left <= 12'd2295) && (m_data.mix_right <= 12'd2295))
        else $error("mix sum out of range");

endmodule

`default_nettype wire
